FILE: hdl/e820m_pkg.sv
// ----------------------------------------------------------------------------
// e820m_pkg
// Shared types, constants and the type-to-class lookup for the memory map
// to legacy map merger.
// ----------------------------------------------------------------------------
package e820m_pkg;

  // Table sizes
  localparam int unsigned BASE_ENTRIES    = 128;
  localparam int unsigned EXT_ENTRIES_MAX = 4096;
  localparam int unsigned EXT_HARD_LIMIT  = 4096;
  localparam int unsigned EXT_LIM_INT     =
    (EXT_ENTRIES_MAX < EXT_HARD_LIMIT) ? EXT_ENTRIES_MAX : EXT_HARD_LIMIT;
  localparam logic [7:0]  BASE_LIM = 8'(BASE_ENTRIES);
  localparam logic [12:0] EXT_LIM  = 13'(EXT_LIM_INT);

  // Page size shift
  localparam int unsigned PAGE_SHIFT = 12;

  // Result queue depth
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Legacy map classes
  typedef enum logic [2:0] {
    CLS_NONE       = 3'd0,
    CLS_RAM        = 3'd1,
    CLS_RESERVED   = 3'd2,
    CLS_ACPI       = 3'd3,
    CLS_NVS        = 3'd4,
    CLS_UNUSABLE   = 3'd5,
    CLS_PERSISTENT = 3'd7
  } cls_t;

  // Firmware type codes
  localparam logic [31:0] EFI_RESERVED     = 32'd0;
  localparam logic [31:0] EFI_LOADER_CODE  = 32'd1;
  localparam logic [31:0] EFI_LOADER_DATA  = 32'd2;
  localparam logic [31:0] EFI_BS_CODE      = 32'd3;
  localparam logic [31:0] EFI_BS_DATA      = 32'd4;
  localparam logic [31:0] EFI_RT_CODE      = 32'd5;
  localparam logic [31:0] EFI_RT_DATA      = 32'd6;
  localparam logic [31:0] EFI_CONVENTIONAL = 32'd7;
  localparam logic [31:0] EFI_UNUSABLE     = 32'd8;
  localparam logic [31:0] EFI_ACPI_RECLAIM = 32'd9;
  localparam logic [31:0] EFI_ACPI_NVS     = 32'd10;
  localparam logic [31:0] EFI_MMIO         = 32'd11;
  localparam logic [31:0] EFI_MMIO_PORT    = 32'd12;
  localparam logic [31:0] EFI_PAL_CODE     = 32'd13;
  localparam logic [31:0] EFI_PERSISTENT   = 32'd14;

  typedef struct packed {
    logic [31:0] efi_type;
    logic [63:0] phys_start;
    logic [51:0] page_count;
    logic        last_descriptor;
  } in_t;

  typedef struct packed {
    logic [63:0] entry_addr;
    logic [63:0] entry_size;
    logic [2:0]  entry_class;
    logic        region;
    logic [11:0] entry_index;
    logic        has_entry;
    logic        status;
    logic [7:0]  base_count;
    logic [12:0] ext_count;
    logic        final_result;
  } out_t;

  // Up to two results pushed per request
  typedef struct packed {
    logic v0;
    logic v1;
    out_t d0;
    out_t d1;
  } push_t;

  // Map a firmware type code to its legacy class
  function automatic cls_t class_of(input logic [31:0] t);
    cls_t c;
    case (t)
      EFI_RESERVED, EFI_RT_CODE, EFI_RT_DATA,
      EFI_MMIO, EFI_MMIO_PORT, EFI_PAL_CODE:        c = CLS_RESERVED;
      EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BS_CODE,
      EFI_BS_DATA, EFI_CONVENTIONAL:                c = CLS_RAM;
      EFI_UNUSABLE:                                 c = CLS_UNUSABLE;
      EFI_ACPI_RECLAIM:                             c = CLS_ACPI;
      EFI_ACPI_NVS:                                 c = CLS_NVS;
      EFI_PERSISTENT:                               c = CLS_PERSISTENT;
      default:                                      c = CLS_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/memory_map_to_e820_merger.sv
// ----------------------------------------------------------------------------
// memory_map_to_e820_merger
// Translates firmware memory descriptors into merged legacy map entries.
// ----------------------------------------------------------------------------
// One descriptor is accepted per clock while in_ready is high. Its class
// lookup, the adjacency add-compare and the merge or emit decision are done
// in the cycle of acceptance against the pending-entry registers, and the
// results (none, one or two) enter a four-entry result queue, from which
// they leave in order. The queue drains one result per cycle while
// out_ready is high, so a map that mostly merges or emits one entry per
// descriptor runs at one descriptor per cycle, while a descriptor that
// produces two results fills the queue faster. in_ready drops when fewer
// than two queue slots are free. The configuration write is taken at any
// time (cfg_ready is always high) but must be done while the block is idle.
// ----------------------------------------------------------------------------
module memory_map_to_e820_merger (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  e820m_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output e820m_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [12:0]      cfg_data
);
  import e820m_pkg::*;

  // Map state
  logic        pend_valid_r, pend_valid_nxt;
  logic [63:0] pend_addr_r,  pend_addr_nxt;
  logic [63:0] pend_size_r,  pend_size_nxt;
  cls_t        pend_class_r, pend_class_nxt;
  logic [7:0]  base_used_r,  base_used_nxt;
  logic [12:0] ext_used_r,   ext_used_nxt;
  logic        failed_r,     failed_nxt;
  logic [12:0] ext_cap_r;

  logic        in_fire;
  logic        room;
  cls_t        cls;
  logic [63:0] bytes;
  logic [12:0] ext_lim;
  logic        merge;
  logic        full;
  out_t        res_a, res_b;
  logic        va, vb;
  push_t       push;

  // Build one result from an entry and the counters that place it
  function automatic out_t mk_result(input logic has, input logic [63:0] addr,
                                     input logic [63:0] size, input cls_t c,
                                     input logic [7:0] base,
                                     input logic [12:0] ext,
                                     input logic st, input logic fin);
    out_t        r;
    logic [12:0] e1;
    logic [7:0]  b1;
    e1 = ext - 13'd1;
    b1 = base - 8'd1;
    r = '0;
    if (has) begin
      r.entry_addr  = addr;
      r.entry_size  = size;
      r.entry_class = c;
      r.region      = (ext != 13'd0);
      r.entry_index = (ext != 13'd0) ? e1[11:0] : {4'd0, b1};
      r.has_entry   = 1'b1;
    end
    r.status = st;
    if (fin) begin
      r.base_count   = base;
      r.ext_count    = ext;
      r.final_result = 1'b1;
    end
    return r;
  endfunction

  assign in_ready  = room;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Decode the request
  assign cls     = class_of(in_data.efi_type);
  assign bytes   = {in_data.page_count, PAGE_SHIFT'(0)};
  assign ext_lim = (ext_cap_r > EXT_LIM) ? EXT_LIM : ext_cap_r;
  assign merge   = pend_valid_r && (cls == pend_class_r) &&
                   ((pend_addr_r + pend_size_r) == in_data.phys_start);

  // Merge, emit or fail
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_size_nxt  = pend_size_r;
    pend_class_nxt = pend_class_r;
    base_used_nxt  = base_used_r;
    ext_used_nxt   = ext_used_r;
    failed_nxt     = failed_r;
    full           = 1'b0;
    res_a          = '0;
    res_b          = '0;
    va             = 1'b0;
    vb             = 1'b0;
    if (in_fire) begin
      if (!failed_r) begin
        if (cls != CLS_NONE) begin
          if (merge) begin
            pend_size_nxt = pend_size_r + bytes;
          end else begin
            if (pend_valid_r) begin
              res_a = mk_result(1'b1, pend_addr_r, pend_size_r, pend_class_r,
                                base_used_r, ext_used_r, 1'b0, 1'b0);
              va    = 1'b1;
            end
            if (base_used_r < BASE_LIM) begin
              base_used_nxt = base_used_r + 8'd1;
            end else if (ext_used_r < ext_lim) begin
              ext_used_nxt = ext_used_r + 13'd1;
            end else begin
              full = 1'b1;
            end
            if (full) begin
              pend_valid_nxt = 1'b0;
              res_b = mk_result(1'b0, '0, '0, CLS_NONE, base_used_r,
                                ext_used_r, 1'b1, 1'b1);
              vb    = 1'b1;
              failed_nxt = !in_data.last_descriptor;
            end else begin
              pend_valid_nxt = 1'b1;
              pend_addr_nxt  = in_data.phys_start;
              pend_size_nxt  = bytes;
              pend_class_nxt = cls;
            end
          end
        end
        // Flush the pending entry at end of map
        if (in_data.last_descriptor && !full) begin
          res_b = mk_result(pend_valid_nxt, pend_addr_nxt, pend_size_nxt,
                            pend_class_nxt, base_used_nxt, ext_used_nxt,
                            1'b0, 1'b1);
          vb    = 1'b1;
        end
      end
      // Clear the map state at end of map
      if (in_data.last_descriptor) begin
        pend_valid_nxt = 1'b0;
        base_used_nxt  = '0;
        ext_used_nxt   = '0;
        failed_nxt     = 1'b0;
      end
    end
  end

  // Pack results toward the queue
  always_comb begin
    push = '0;
    if (va) begin
      push.v0 = 1'b1;
      push.d0 = res_a;
      push.v1 = vb;
      push.d1 = res_b;
    end else begin
      push.v0 = vb;
      push.d0 = res_b;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      base_used_r  <= '0;
      ext_used_r   <= '0;
      failed_r     <= 1'b0;
      ext_cap_r    <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      base_used_r  <= base_used_nxt;
      ext_used_r   <= ext_used_nxt;
      failed_r     <= failed_nxt;
      if (cfg_valid && cfg_ready) begin
        ext_cap_r <= cfg_data;
      end
    end
  end

  // Hold pending entry payload
  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    pend_size_r  <= pend_size_nxt;
    pend_class_r <= pend_class_nxt;
  end

  e820m_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Check map-state invariants
  a_fail_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !pend_valid_r)
    else $error("pending entry held after failure");

  a_ext_after_base: assert property (@(posedge clk) disable iff (!rst_n)
    (base_used_r < BASE_LIM) |-> (ext_used_r == 13'd0))
    else $error("extension used before base table full");

  a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ext_used_r <= EXT_LIM)
    else $error("extension count beyond limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_descriptor) |=>
      (!pend_valid_r && !failed_r && base_used_r == 8'd0))
    else $error("map state not cleared at end of map");

endmodule

FILE: hdl/e820m_out_fifo.sv
// ----------------------------------------------------------------------------
// e820m_out_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module e820m_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  e820m_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output e820m_pkg::out_t out_data
);
  import e820m_pkg::*;

  out_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_PTR_W-1:0] wr_ptr_1;
  logic [OUT_CNT_W-1:0] push_n;
  logic                 pop;

  // Status toward both sides
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr_r + OUT_PTR_W'(1);

  // Advance pointers and count
  always_comb begin
    push_n     = OUT_CNT_W'(push.v0) + OUT_CNT_W'(push.v1);
    wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
    cnt_nxt    = cnt_r + push_n - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.d0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_1] <= push.d1;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the memory map to legacy map merger: descriptor
// maps are pushed through the input channel and every emitted entry is
// compared against a cycle-free model of the merge and table-fill rules.
// ----------------------------------------------------------------------------
module tb;
  import e820m_pkg::*;

  // Directed step: one descriptor, with an optional typed-in result
  typedef struct packed {
    in_t  d;
    logic typed;
    out_t res;
  } step_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data  = '0;

  int errors    = 0;
  int sent_n    = 0;
  int hold_cnt  = 0;
  bit no_idle   = 1'b0;
  bit hold_req  = 1'b0;

  // Model state: configuration, pending entry and table fill
  logic [12:0] cap_q = '0;
  logic        pend_v;
  logic [63:0] pend_addr;
  logic [63:0] pend_size;
  cls_t        pend_cls;
  logic [7:0]  base_n;
  logic [12:0] ext_n;
  logic        failed_q;

  // Legacy map entries still to come out of the block, oldest first
  out_t entry_q[$];

  memory_map_to_e820_merger DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Map a firmware type code to its legacy class
  function automatic cls_t legacy_class(input logic [31:0] t);
    case (t)
      EFI_RESERVED, EFI_RT_CODE, EFI_RT_DATA,
      EFI_MMIO, EFI_MMIO_PORT, EFI_PAL_CODE:  return CLS_RESERVED;
      EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BS_CODE,
      EFI_BS_DATA, EFI_CONVENTIONAL:          return CLS_RAM;
      EFI_UNUSABLE:                           return CLS_UNUSABLE;
      EFI_ACPI_RECLAIM:                       return CLS_ACPI;
      EFI_ACPI_NVS:                           return CLS_NVS;
      EFI_PERSISTENT:                         return CLS_PERSISTENT;
      default:                                return CLS_NONE;
    endcase
  endfunction

  // Saturate the extension capacity
  function automatic logic [12:0] ext_lim();
    return (cap_q > EXT_LIM) ? EXT_LIM : cap_q;
  endfunction

  function automatic void clear_map();
    pend_v    = 1'b0;
    pend_addr = '0;
    pend_size = '0;
    pend_cls  = CLS_NONE;
    base_n    = '0;
    ext_n     = '0;
    failed_q  = 1'b0;
  endfunction

  // Build a result from the pending entry and the current counts
  function automatic out_t make_entry(input bit has, input bit st, input bit fin);
    out_t r;
    r = '0;
    if (has) begin
      r.entry_addr  = pend_addr;
      r.entry_size  = pend_size;
      r.entry_class = pend_cls;
      r.region      = (ext_n != 0);
      r.entry_index = (ext_n != 0) ? 12'(ext_n - 13'd1) : 12'(base_n - 8'd1);
      r.has_entry   = 1'b1;
    end
    r.status = st;
    if (fin) begin
      r.base_count   = base_n;
      r.ext_count    = ext_n;
      r.final_result = 1'b1;
    end
    return r;
  endfunction

  // Advance the model by one accepted descriptor; n counts the new results
  task automatic merge_descriptor(input in_t d, output int n);
    cls_t        c;
    logic [63:0] bytes;
    n     = 0;
    c     = legacy_class(d.efi_type);
    bytes = 64'(d.page_count) << PAGE_SHIFT;
    // drop everything after a failure until the map ends
    if (failed_q) begin
      if (d.last_descriptor) clear_map();
      return;
    end
    if (c != CLS_NONE) begin
      if (pend_v && c == pend_cls && pend_addr + pend_size == d.phys_start) begin
        pend_size += bytes;
      end else begin
        if (pend_v) begin
          entry_q.push_back(make_entry(1'b1, 1'b0, 1'b0));
          n++;
        end
        if (base_n < BASE_LIM) begin
          base_n++;
        end else if (ext_n < ext_lim()) begin
          ext_n++;
        end else begin
          // no slot left: report the error once
          pend_v = 1'b0;
          entry_q.push_back(make_entry(1'b0, 1'b1, 1'b1));
          n++;
          if (d.last_descriptor) clear_map();
          else failed_q = 1'b1;
          return;
        end
        pend_v    = 1'b1;
        pend_addr = d.phys_start;
        pend_size = bytes;
        pend_cls  = c;
      end
    end
    // flush the pending entry at the end of the map
    if (d.last_descriptor) begin
      entry_q.push_back(make_entry(pend_v, 1'b0, 1'b1));
      n++;
      clear_map();
    end
  endtask

  function automatic in_t desc(input logic [31:0] t, input logic [63:0] s,
                               input logic [51:0] p, input bit l);
    in_t d;
    d.efi_type        = t;
    d.phys_start      = s;
    d.page_count      = p;
    d.last_descriptor = l;
    return d;
  endfunction

  // Closing result of a one-entry map, or of an empty one
  function automatic out_t map_end(input bit has, input logic [63:0] a,
                                   input logic [63:0] sz, input cls_t c);
    out_t r;
    r = '0;
    if (has) begin
      r.entry_addr  = a;
      r.entry_size  = sz;
      r.entry_class = c;
      r.has_entry   = 1'b1;
      r.base_count  = 8'd1;
    end
    r.final_result = 1'b1;
    return r;
  endfunction

  // Random descriptor; merge_pct steers how often it continues the pending entry
  function automatic in_t random_desc(input int merge_pct);
    in_t d;
    int  pick;
    d = '0;
    pick = $urandom_range(99);
    d.efi_type   = ($urandom_range(99) < 4) ? 32'($urandom) : 32'($urandom_range(14));
    d.phys_start = {$urandom, $urandom};
    if (pend_v && pick < merge_pct) begin
      d.phys_start = pend_addr + pend_size;
      while (legacy_class(d.efi_type) != pend_cls) d.efi_type = 32'($urandom_range(14));
    end else if (pend_v && pick < merge_pct + 15) begin
      d.phys_start = pend_addr + pend_size;
    end
    pick = $urandom_range(99);
    if (pick < 10) d.page_count = '0;
    else if (pick < 30) d.page_count = 52'({$urandom, $urandom});
    else d.page_count = 52'($urandom_range(1, 64));
    return d;
  endfunction

  // Drive one request and predict its results once it is accepted
  task automatic offer(input in_t d, output int n);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_n++;
    merge_descriptor(d, n);
  endtask

  // Hold the input until every expected entry is out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cap(input logic [12:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_q = v;
  endtask

  task automatic run_map(input int len, input int merge_pct);
    in_t d;
    int  n;
    int  j;
    for (j = 0; j < len; j++) begin
      d = random_desc(merge_pct);
      d.last_descriptor = (j == len - 1);
      offer(d, n);
    end
  endtask

  // Fill both tables, merge once while full, then overflow
  task automatic overflow_map(input bit end_on_overflow);
    in_t d;
    int  n;
    int  k;
    bit  merged_full;
    merged_full = 1'b0;
    while (!failed_q) begin
      d = random_desc(30);
      d.last_descriptor = 1'b0;
      if (pend_v && base_n == BASE_LIM && ext_n >= ext_lim()) begin
        if (!merged_full) begin
          d = random_desc(100);
          d.last_descriptor = 1'b0;
          merged_full = 1'b1;
        end else begin
          // start a fresh entry with no slot left
          d.efi_type        = EFI_CONVENTIONAL;
          d.phys_start      = pend_addr + pend_size + 64'h1000;
          d.last_descriptor = end_on_overflow;
        end
      end
      offer(d, n);
      if (d.last_descriptor) return;
    end
    // feed the ignored tail of the failed map
    for (k = 0; k < 4; k++) begin
      d = random_desc(30);
      d.last_descriptor = (k == 3);
      offer(d, n);
    end
  endtask

  function automatic void check_field(input string fld, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", fld, want, got);
      errors++;
    end
  endfunction

  task automatic check_entry(input out_t got);
    out_t want;
    if (entry_q.size() == 0) begin
      $error("entry with nothing expected: addr %0h size %0h", got.entry_addr,
             got.entry_size);
      errors++;
    end else begin
      want = entry_q.pop_front();
      check_field("entry_addr",   want.entry_addr,   got.entry_addr);
      check_field("entry_size",   want.entry_size,   got.entry_size);
      check_field("entry_class",  want.entry_class,  got.entry_class);
      check_field("region",       want.region,       got.region);
      check_field("entry_index",  want.entry_index,  got.entry_index);
      check_field("has_entry",    want.has_entry,    got.has_entry);
      check_field("status",       want.status,       got.status);
      check_field("base_count",   want.base_count,   got.base_count);
      check_field("ext_count",    want.ext_count,    got.ext_count);
      check_field("final_result", want.final_result, got.final_result);
    end
  endtask

  // Take results, with random back-pressure and an occasional long hold
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_entry(out_data);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 6);
      end
    end
  end

  initial begin : stimulus
    step_t       plan[$];
    int          n;
    int          ph;
    int          phase_end;
    logic [12:0] cap;

    clear_map();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_cap(13'd2);

    // One-entry maps, empty map, extremes
    plan.push_back('{desc(EFI_CONVENTIONAL, 64'h1000, 52'd1, 1'b1), 1'b1,
                     map_end(1'b1, 64'h1000, 64'h1000, CLS_RAM)});
    plan.push_back('{desc(32'hFFFF_FFFF, '1, '1, 1'b1), 1'b1,
                     map_end(1'b0, '0, '0, CLS_NONE)});
    plan.push_back('{desc(EFI_PERSISTENT, '1, '1, 1'b1), 1'b1,
                     map_end(1'b1, '1, 64'hFFFF_FFFF_FFFF_F000, CLS_PERSISTENT)});
    // Walk type codes 0 to 13 over contiguous pages
    plan.push_back('{desc(EFI_RESERVED,     64'h0,    52'd0, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_LOADER_CODE,  64'h0,    52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_LOADER_DATA,  64'h1000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_BS_CODE,      64'h2000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_BS_DATA,      64'h3000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_CONVENTIONAL, 64'h4000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_RT_CODE,      64'h5000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_RT_DATA,      64'h6000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_MMIO,         64'h7000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_MMIO_PORT,    64'h8000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_PAL_CODE,     64'h9000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_UNUSABLE,     64'hA000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_ACPI_RECLAIM, 64'hB000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_ACPI_NVS,     64'hC000, 52'd1, 1'b0), 1'b0, '0});
    // Skip an unknown type, merge across it, end the map on an unknown type
    plan.push_back('{desc(32'd15,           64'hD000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_ACPI_NVS,     64'hD000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(32'h8000_0000,    64'h0,    52'd0, 1'b1), 1'b0, '0});
    // Merge with a wrapping size and across address zero
    plan.push_back('{desc(EFI_PERSISTENT, 64'hFFFF_FFFF_FFFF_F000, '1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_PERSISTENT, 64'hFFFF_FFFF_FFFF_E000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_LOADER_CODE, 64'hFFFF_FFFF_FFFF_F000, 52'd1, 1'b0), 1'b0, '0});
    plan.push_back('{desc(EFI_LOADER_CODE, 64'h0, 52'd1, 1'b1), 1'b0, '0});

    foreach (plan[i]) begin
      offer(plan[i].d, n);
      if (plan[i].typed) begin
        // replace the prediction with the typed-in result
        repeat (n) void'(entry_q.pop_back());
        entry_q.push_back(plan[i].res);
      end
    end

    // Random maps over several capacity settings
    for (ph = 0; ph < 6; ph++) begin
      wait_drain();
      case (ph)
        0:       cap = 13'd0;
        1:       cap = 13'd3;
        2:       cap = 13'h1FFF;
        3:       cap = 13'd1;
        4:       cap = 13'd4096;
        default: cap = 13'($urandom_range(8191));
      endcase
      write_cap(cap);
      no_idle = (ph == 2);
      if (ph == 1 || ph == 3) hold_req = 1'b1;
      phase_end = sent_n + 220;
      if (cap <= 13'd5) overflow_map(ph == 1);
      else run_map(170, 5);
      while (sent_n < phase_end) begin
        run_map($urandom_range(1, 24), ($urandom_range(9) == 0) ? 0 : 40);
      end
    end

    wait_drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
